[sv/ngss_pkg.sv]
package ngss_pkg;

  localparam int LINE_CHARS_DEF  = 128;
  localparam int MAX_SATS_DEF    = 16;
  localparam int MAX_TOKENS_DEF  = 21;
  localparam int TOKEN_CHARS_DEF = 15;

  localparam int FIELD_W    = 14;
  localparam int TALLY_W    = 5;
  localparam int CLASS_W    = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;
  localparam int SNR_MIN_W  = 7;
  localparam int NEEDED_W   = 5;

  localparam logic [FIELD_W-1:0] FIELD_SAT = 14'd9999;
  localparam logic [3:0]         MIN_TEXT  = 4'd10;

  localparam logic [CFG_IDX_W-1:0] REG_STRONG_SNR_MIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STRONG_NEEDED  = 2'd1;

  localparam logic [SNR_MIN_W-1:0] STRONG_SNR_MIN_RST = 7'd28;
  localparam logic [NEEDED_W-1:0]  STRONG_NEEDED_RST  = 5'd4;

  localparam logic [CLASS_W-1:0] CLS_NONE   = 2'd0;
  localparam logic [CLASS_W-1:0] CLS_WEAK   = 2'd1;
  localparam logic [CLASS_W-1:0] CLS_SOME   = 2'd2;
  localparam logic [CLASS_W-1:0] CLS_ENOUGH = 2'd3;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_G      = 8'h47;
  localparam logic [7:0] CH_S      = 8'h53;
  localparam logic [7:0] CH_V      = 8'h56;

  typedef struct packed {
    logic neg;
    logic started;
    logic stopped;
  } dec_flags_t;

endpackage

[sv/ngss_in_if.sv]
interface ngss_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

[sv/ngss_out_if.sv]
interface ngss_out_if;
  logic                         valid;
  logic                         ready;
  logic [ngss_pkg::TALLY_W-1:0] with_signal;
  logic [ngss_pkg::TALLY_W-1:0] strong_sats;
  logic [ngss_pkg::FIELD_W-1:0] max_snr;
  logic [ngss_pkg::FIELD_W-1:0] total_in_view;
  logic [ngss_pkg::CLASS_W-1:0] signal_class;

  modport source (output valid, output with_signal, output strong_sats, output max_snr,
                  output total_in_view, output signal_class, input ready);
  modport sink   (input valid, input with_signal, input strong_sats, input max_snr,
                  input total_in_view, input signal_class, output ready);
endinterface

[sv/ngss_cfg_if.sv]
interface ngss_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [ngss_pkg::CFG_IDX_W-1:0]  idx;
  logic [ngss_pkg::CFG_DATA_W-1:0] wdata;

  modport source (output valid, output idx, output wdata, input ready);
  modport sink   (input valid, input idx, input wdata, output ready);
endinterface

[sv/nmea_gsv_signal_summary.sv]
// GSV signal summary over a raw NMEA character stream.
// in_ch  : one received character per item (rx_byte), valid/ready.
// out_ch : one summary item per final GSV message of a cycle: satellites
//          with signal, strong satellites, peak SNR, in-view count, class.
// cfg_ch : register writes, always ready; index 0 strong SNR threshold,
//          index 1 strong satellites needed. Write only while idle.
// A character is held in an input register, then processed combinationally
// by the line, token and tally logic, which loads the output register
// when a line end completes a final message. The summary enters that
// register once its line-end character is processed with the output free;
// throughput is one character per cycle while no summary waits unclaimed,
// set by the single per-character tokenizer and decimal accumulator update.
// The input register still takes one character while a summary waits in
// the output register; once a character reaches processing while the summary
// is still unclaimed, input stalls until out_ch.ready is seen.
// Reset (rst_n low, synchronous) clears line state, header fields, tallies
// and both handshakes, and restores the register defaults (28 and 4).
module nmea_gsv_signal_summary #(
  parameter int LINE_CHARS  = ngss_pkg::LINE_CHARS_DEF,
  parameter int MAX_SATS    = ngss_pkg::MAX_SATS_DEF,
  parameter int MAX_TOKENS  = ngss_pkg::MAX_TOKENS_DEF,
  parameter int TOKEN_CHARS = ngss_pkg::TOKEN_CHARS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  ngss_in_if.sink    in_ch,
  ngss_out_if.source out_ch,
  ngss_cfg_if.sink   cfg_ch
);

  localparam int FW      = ngss_pkg::FIELD_W;
  localparam int LLW     = $clog2(LINE_CHARS);
  localparam int TCW     = $clog2(MAX_TOKENS + 1);
  localparam int TKW     = $clog2(TOKEN_CHARS + 1);
  localparam int SW      = $clog2(MAX_SATS + 1);
  localparam int NGROUPS = (MAX_TOKENS - 4) / 4;
  localparam int CMPW    = (SW > ngss_pkg::NEEDED_W) ? SW : ngss_pkg::NEEDED_W;
  localparam int ACCW    = FW + 4;

  // input register
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       out_free;
  logic       proc;

  // configuration
  logic [ngss_pkg::SNR_MIN_W-1:0] snr_min_r;
  logic [ngss_pkg::NEEDED_W-1:0]  needed_r;

  // line state
  logic [LLW-1:0]            line_len_r, line_len_nxt;
  logic [3:0]                text_len_r, text_len_nxt;
  logic                      text_closed_r, text_closed_nxt;
  logic                      dollar_r, dollar_nxt;
  logic                      gsv_r, gsv_nxt;
  logic [15:0]               prior_r, prior_nxt;
  logic [TCW-1:0]            tok_cnt_r, tok_cnt_nxt;
  logic [TKW-1:0]            tok_chars_r, tok_chars_nxt;
  logic                      star_r, star_nxt;
  logic [FW-1:0]             field_r, field_nxt;
  ngss_pkg::dec_flags_t      dec_r, dec_nxt;

  // header fields and group slots
  logic [FW-1:0]             total_r, total_nxt;
  logic [FW-1:0]             msg_r, msg_nxt;
  logic [FW-1:0]             in_view_r, in_view_nxt;
  logic [NGROUPS-1:0]        prn_pos_r, prn_pos_nxt;
  logic [FW-1:0]             snr_r [NGROUPS];
  logic [FW-1:0]             snr_nxt [NGROUPS];

  // tallies
  logic [SW-1:0]             sat_r, sat_nxt;
  logic [SW-1:0]             sig_r, sig_nxt;
  logic [SW-1:0]             strong_r, strong_nxt;
  logic [FW-1:0]             max_r, max_nxt;

  // result
  logic                      res_valid;
  logic [ngss_pkg::CLASS_W-1:0] res_class;
  logic                      out_valid_r;
  logic [ngss_pkg::TALLY_W-1:0] out_sig_r, out_strong_r;
  logic [FW-1:0]             out_max_r, out_view_r;
  logic [ngss_pkg::CLASS_W-1:0] out_class_r;

  // scratch
  logic [7:0]                ch;
  logic                      line_ok;
  logic [ACCW-1:0]           acc;
  logic [TCW-1:0]            tok_off;
  logic [TCW-3:0]            grp;
  logic [FW-1:0]             tok_val;

  assign out_free    = !out_valid_r || out_ch.ready;
  assign proc        = s1_valid_r && out_free;
  assign in_ch.ready = !s1_valid_r || out_free;
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid         = out_valid_r;
  assign out_ch.with_signal   = out_sig_r;
  assign out_ch.strong_sats   = out_strong_r;
  assign out_ch.max_snr       = out_max_r;
  assign out_ch.total_in_view = out_view_r;
  assign out_ch.signal_class  = out_class_r;

  assign ch      = s1_byte_r;
  assign line_ok = dollar_r && (text_len_r >= ngss_pkg::MIN_TEXT) && gsv_r &&
                   (tok_cnt_r >= TCW'(4));
  assign acc     = ACCW'(field_r) * ACCW'(10) + ACCW'(ch - ngss_pkg::CH_0);
  assign tok_off = tok_cnt_r - TCW'(4);
  assign grp     = tok_off[TCW-1:2];
  assign tok_val = dec_r.neg ? '0 : field_r;

  always_comb begin
    line_len_nxt    = line_len_r;
    text_len_nxt    = text_len_r;
    text_closed_nxt = text_closed_r;
    dollar_nxt      = dollar_r;
    gsv_nxt         = gsv_r;
    prior_nxt       = prior_r;
    tok_cnt_nxt     = tok_cnt_r;
    tok_chars_nxt   = tok_chars_r;
    star_nxt        = star_r;
    field_nxt       = field_r;
    dec_nxt         = dec_r;
    total_nxt       = total_r;
    msg_nxt         = msg_r;
    in_view_nxt     = in_view_r;
    prn_pos_nxt     = prn_pos_r;
    snr_nxt         = snr_r;
    sat_nxt         = sat_r;
    sig_nxt         = sig_r;
    strong_nxt      = strong_r;
    max_nxt         = max_r;
    res_valid       = 1'b0;

    if (proc) begin
      if (ch == ngss_pkg::CH_LF || ch == ngss_pkg::CH_CR) begin
        if (line_len_r != '0) begin
          if (line_ok) begin
            if (msg_r == FW'(1)) begin
              sat_nxt    = '0;
              sig_nxt    = '0;
              strong_nxt = '0;
              max_nxt    = '0;
            end
            // groups commit in order; the satellite cap stops further adds
            for (int g = 0; g < NGROUPS; g++) begin
              if ((4 * g + 7) < int'(tok_cnt_r) && sat_nxt < SW'(MAX_SATS) &&
                  prn_pos_r[g]) begin
                sat_nxt = sat_nxt + SW'(1);
                if (snr_r[g] != '0) begin
                  sig_nxt = sig_nxt + SW'(1);
                  if (snr_r[g] >= FW'(snr_min_r)) begin
                    strong_nxt = strong_nxt + SW'(1);
                  end
                  if (snr_r[g] > max_nxt) begin
                    max_nxt = snr_r[g];
                  end
                end
              end
            end
            res_valid = (total_r != '0) && (msg_r == total_r);
          end
          line_len_nxt    = '0;
          text_len_nxt    = '0;
          text_closed_nxt = 1'b0;
          dollar_nxt      = 1'b0;
          gsv_nxt         = 1'b0;
          prior_nxt       = '0;
          tok_cnt_nxt     = '0;
          tok_chars_nxt   = '0;
          star_nxt        = 1'b0;
          field_nxt       = '0;
          dec_nxt         = '0;
        end
      end else if (line_len_r < LLW'(LINE_CHARS - 1)) begin
        line_len_nxt = line_len_r + LLW'(1);
        if (!text_closed_r) begin
          if (ch == ngss_pkg::CH_NUL) begin
            text_closed_nxt = 1'b1;
          end else begin
            if (text_len_r == '0) begin
              dollar_nxt = (ch == ngss_pkg::CH_DOLLAR);
            end
            if (text_len_r < ngss_pkg::MIN_TEXT) begin
              text_len_nxt = text_len_r + 4'd1;
            end
            if (ch == ngss_pkg::CH_V && prior_r == {ngss_pkg::CH_G, ngss_pkg::CH_S}) begin
              gsv_nxt = 1'b1;
            end
            prior_nxt = {prior_r[7:0], ch};
            if (!star_r && tok_cnt_r < TCW'(MAX_TOKENS)) begin
              if (ch == ngss_pkg::CH_COMMA || ch == ngss_pkg::CH_STAR) begin
                if (tok_cnt_r == TCW'(1)) begin
                  total_nxt = tok_val;
                end else if (tok_cnt_r == TCW'(2)) begin
                  msg_nxt = tok_val;
                end else if (tok_cnt_r == TCW'(3)) begin
                  in_view_nxt = tok_val;
                end else if (tok_cnt_r >= TCW'(4)) begin
                  for (int k = 0; k < NGROUPS; k++) begin
                    if (int'(grp) == k) begin
                      if (tok_off[1:0] == 2'd0) begin
                        prn_pos_nxt[k] = (tok_val != '0);
                      end else if (tok_off[1:0] == 2'd3) begin
                        snr_nxt[k] = tok_val;
                      end
                    end
                  end
                end
                tok_cnt_nxt   = tok_cnt_r + TCW'(1);
                tok_chars_nxt = '0;
                field_nxt     = '0;
                dec_nxt       = '0;
                if (ch == ngss_pkg::CH_STAR) begin
                  star_nxt = 1'b1;
                end
              end else if (tok_chars_r < TKW'(TOKEN_CHARS)) begin
                tok_chars_nxt = tok_chars_r + TKW'(1);
                if (!dec_r.stopped) begin
                  if (ch >= ngss_pkg::CH_0 && ch <= ngss_pkg::CH_9) begin
                    field_nxt       = (acc > ACCW'(ngss_pkg::FIELD_SAT)) ?
                                      ngss_pkg::FIELD_SAT : acc[FW-1:0];
                    dec_nxt.started = 1'b1;
                  end else if (!dec_r.started) begin
                    if (ch == ngss_pkg::CH_SPACE || ch == ngss_pkg::CH_TAB ||
                        ch == ngss_pkg::CH_VT || ch == ngss_pkg::CH_FF) begin
                      dec_nxt = dec_r;
                    end else if (ch == ngss_pkg::CH_PLUS) begin
                      dec_nxt.started = 1'b1;
                    end else if (ch == ngss_pkg::CH_MINUS) begin
                      dec_nxt.started = 1'b1;
                      dec_nxt.neg     = 1'b1;
                    end else begin
                      dec_nxt.stopped = 1'b1;
                    end
                  end else begin
                    dec_nxt.stopped = 1'b1;
                  end
                end
              end
            end
          end
        end
      end
    end
  end

  always_comb begin
    if (sig_nxt == '0) begin
      res_class = ngss_pkg::CLS_NONE;
    end else if (CMPW'(strong_nxt) >= CMPW'(needed_r)) begin
      res_class = ngss_pkg::CLS_ENOUGH;
    end else if (strong_nxt != '0) begin
      res_class = ngss_pkg::CLS_SOME;
    end else begin
      res_class = ngss_pkg::CLS_WEAK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      snr_min_r <= ngss_pkg::STRONG_SNR_MIN_RST;
      needed_r  <= ngss_pkg::STRONG_NEEDED_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.idx)
        ngss_pkg::REG_STRONG_SNR_MIN: snr_min_r <= cfg_ch.wdata[ngss_pkg::SNR_MIN_W-1:0];
        ngss_pkg::REG_STRONG_NEEDED:  needed_r  <= cfg_ch.wdata[ngss_pkg::NEEDED_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      line_len_r    <= '0;
      text_len_r    <= '0;
      text_closed_r <= 1'b0;
      dollar_r      <= 1'b0;
      gsv_r         <= 1'b0;
      prior_r       <= '0;
      tok_cnt_r     <= '0;
      tok_chars_r   <= '0;
      star_r        <= 1'b0;
      field_r       <= '0;
      dec_r         <= '0;
      total_r       <= '0;
      msg_r         <= '0;
      in_view_r     <= '0;
      prn_pos_r     <= '0;
      for (int k = 0; k < NGROUPS; k++) begin
        snr_r[k] <= '0;
      end
      sat_r         <= '0;
      sig_r         <= '0;
      strong_r      <= '0;
      max_r         <= '0;
    end else begin
      if (in_ch.ready) begin
        s1_valid_r <= in_ch.valid;
      end
      if (out_free) begin
        out_valid_r <= res_valid;
      end
      line_len_r    <= line_len_nxt;
      text_len_r    <= text_len_nxt;
      text_closed_r <= text_closed_nxt;
      dollar_r      <= dollar_nxt;
      gsv_r         <= gsv_nxt;
      prior_r       <= prior_nxt;
      tok_cnt_r     <= tok_cnt_nxt;
      tok_chars_r   <= tok_chars_nxt;
      star_r        <= star_nxt;
      field_r       <= field_nxt;
      dec_r         <= dec_nxt;
      total_r       <= total_nxt;
      msg_r         <= msg_nxt;
      in_view_r     <= in_view_nxt;
      prn_pos_r     <= prn_pos_nxt;
      snr_r         <= snr_nxt;
      sat_r         <= sat_nxt;
      sig_r         <= sig_nxt;
      strong_r      <= strong_nxt;
      max_r         <= max_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_byte_r <= in_ch.rx_byte;
    end
    if (res_valid) begin
      out_sig_r    <= ngss_pkg::TALLY_W'(sig_nxt);
      out_strong_r <= ngss_pkg::TALLY_W'(strong_nxt);
      out_max_r    <= max_nxt;
      out_view_r   <= in_view_r;
      out_class_r  <= res_class;
    end
  end

endmodule

[sv/ngss_checker.sv]
module ngss_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [ngss_pkg::TALLY_W-1:0] out_with_signal,
  input logic [ngss_pkg::TALLY_W-1:0] out_strong_sats,
  input logic [ngss_pkg::FIELD_W-1:0] out_max_snr,
  input logic [ngss_pkg::FIELD_W-1:0] out_total_in_view,
  input logic [ngss_pkg::CLASS_W-1:0] out_signal_class
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("summary item dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_with_signal) && $stable(out_strong_sats) &&
      $stable(out_max_snr) && $stable(out_total_in_view) && $stable(out_signal_class))
    else $error("summary item changed while stalled");

  a_class_none: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_with_signal == '0) == (out_signal_class == ngss_pkg::CLS_NONE)) &&
      ((out_with_signal == '0) == (out_max_snr == '0)))
    else $error("class or peak SNR disagrees with signal count");

  a_strong_le: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_strong_sats <= out_with_signal) &&
      ((out_signal_class == ngss_pkg::CLS_WEAK) == (out_with_signal != '0 &&
        out_strong_sats == '0 && out_signal_class != ngss_pkg::CLS_ENOUGH)))
    else $error("strong count inconsistent with class");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("summary valid after reset");

endmodule

bind nmea_gsv_signal_summary ngss_checker u_ngss_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_with_signal   (out_ch.with_signal),
  .out_strong_sats   (out_ch.strong_sats),
  .out_max_snr       (out_ch.max_snr),
  .out_total_in_view (out_ch.total_in_view),
  .out_signal_class  (out_ch.signal_class)
);

[sim/tb_nmea_gsv_signal_summary.sv]
`timescale 1ns / 1ps

module tb_nmea_gsv_signal_summary;
  import ngss_pkg::*;

  typedef struct packed {
    logic [TALLY_W-1:0] with_signal;
    logic [TALLY_W-1:0] strong_sats;
    logic [FIELD_W-1:0] max_snr;
    logic [FIELD_W-1:0] total_in_view;
    logic [CLASS_W-1:0] signal_class;
  } summary_t;

  logic clk = 1'b0;
  logic rst_n;

  ngss_in_if  in_ch();
  ngss_out_if out_ch();
  ngss_cfg_if cfg_ch();

  nmea_gsv_signal_summary u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [7:0] chars_queued[$];
  summary_t   summaries_due[$];
  int chars_pushed = 0;
  int chars_offered = 0;
  int chars_taken = 0;
  int errors = 0;
  int in_gap = 0;
  int out_gap = 0;
  bit calm = 1'b0;
  string talker_ids[4] = '{"GP", "GL", "GA", "GN"};

  // GSV tracking state
  logic [SNR_MIN_W-1:0] snr_min_r = STRONG_SNR_MIN_RST;
  logic [NEEDED_W-1:0]  needed_r  = STRONG_NEEDED_RST;
  int line_len = 0, text_len = 0;
  bit text_done = 0, dollar_seen = 0, gsv_seen = 0, star_seen = 0;
  logic [15:0] last_two = '0;
  int tok_idx = 0, tok_len = 0, acc = 0;
  dec_flags_t acc_flags = '0;
  int msg_total = 0, msg_num = 0, in_view = 0;
  bit grp_prn[8];
  int grp_snr[8];
  int sat_cnt = 0, sig_cnt = 0, strong_cnt = 0, peak_snr = 0;

  task automatic report(string what);
    errors++;
    $display("%0t ns: mismatch: %s", $time, what);
  endtask

  function void gsv_clear_line();
    line_len = 0;
    text_len = 0;
    text_done = 0;
    dollar_seen = 0;
    gsv_seen = 0;
    star_seen = 0;
    last_two = '0;
    tok_idx = 0;
    tok_len = 0;
    acc = 0;
    acc_flags = '0;
  endfunction

  function void gsv_decode(logic [7:0] c);
    if (acc_flags.stopped) return;
    if (c >= CH_0 && c <= CH_9) begin
      acc = acc * 10 + int'(c - CH_0);
      if (acc > int'(FIELD_SAT)) acc = int'(FIELD_SAT);
      acc_flags.started = 1'b1;
    end else if (!acc_flags.started) begin
      if (c inside {CH_SPACE, CH_TAB, CH_VT, CH_FF}) begin
      end else if (c == CH_PLUS) begin
        acc_flags.started = 1'b1;
      end else if (c == CH_MINUS) begin
        acc_flags.started = 1'b1;
        acc_flags.neg = 1'b1;
      end else begin
        acc_flags.stopped = 1'b1;
      end
    end else begin
      acc_flags.stopped = 1'b1;
    end
  endfunction

  function void gsv_close_field();
    int v, g;
    v = acc_flags.neg ? -acc : acc;
    if (tok_idx == 1) begin
      msg_total = v > 0 ? v : 0;
    end else if (tok_idx == 2) begin
      msg_num = v > 0 ? v : 0;
    end else if (tok_idx == 3) begin
      in_view = v;
    end else if (tok_idx >= 4) begin
      g = (tok_idx - 4) / 4;
      if (g < 8) begin
        if ((tok_idx - 4) % 4 == 0) grp_prn[g] = v > 0;
        else if ((tok_idx - 4) % 4 == 3) grp_snr[g] = v;
      end
    end
    tok_idx++;
    tok_len = 0;
    acc = 0;
    acc_flags = '0;
  endfunction

  function void gsv_text_char(logic [7:0] c);
    if (text_len == 0) dollar_seen = (c == CH_DOLLAR);
    text_len++;
    if (c == CH_V && last_two == {CH_G, CH_S}) gsv_seen = 1'b1;
    last_two = {last_two[7:0], c};
    if (star_seen || tok_idx >= MAX_TOKENS_DEF) return;
    if (c == CH_COMMA || c == CH_STAR) begin
      gsv_close_field();
      if (c == CH_STAR) star_seen = 1'b1;
    end else if (tok_len < TOKEN_CHARS_DEF) begin
      tok_len++;
      gsv_decode(c);
    end
  endfunction

  function void gsv_end_of_line();
    int g;
    summary_t s;
    if (!dollar_seen || text_len < int'(MIN_TEXT) || !gsv_seen || tok_idx < 4) return;
    if (msg_num == 1) begin
      sat_cnt = 0;
      sig_cnt = 0;
      strong_cnt = 0;
      peak_snr = 0;
    end
    for (g = 0; g < 8 && 4 * g + 7 < tok_idx; g++) begin
      if (sat_cnt >= MAX_SATS_DEF) break;
      if (!grp_prn[g]) continue;
      sat_cnt++;
      if (grp_snr[g] > 0) begin
        sig_cnt++;
        if (grp_snr[g] >= int'(snr_min_r)) strong_cnt++;
        if (grp_snr[g] > peak_snr) peak_snr = grp_snr[g];
      end
    end
    if (msg_total == 0 || msg_num != msg_total) return;
    s.with_signal   = TALLY_W'(sig_cnt);
    s.strong_sats   = TALLY_W'(strong_cnt);
    s.max_snr       = FIELD_W'(peak_snr);
    s.total_in_view = FIELD_W'(in_view > 0 ? in_view : 0);
    if (sig_cnt == 0) s.signal_class = CLS_NONE;
    else if (strong_cnt >= int'(needed_r)) s.signal_class = CLS_ENOUGH;
    else if (strong_cnt > 0) s.signal_class = CLS_SOME;
    else s.signal_class = CLS_WEAK;
    summaries_due.push_back(s);
  endfunction

  function void gsv_take_char(logic [7:0] c);
    if (c == CH_LF || c == CH_CR) begin
      if (line_len > 0) begin
        gsv_end_of_line();
        gsv_clear_line();
      end
    end else if (line_len < LINE_CHARS_DEF - 1) begin
      line_len++;
      if (!text_done) begin
        if (c == CH_NUL) text_done = 1'b1;
        else gsv_text_char(c);
      end
    end
  endfunction

  task automatic check_summary();
    summary_t want;
    if (summaries_due.size() == 0) begin
      report("summary item with none expected");
      return;
    end
    want = summaries_due.pop_front();
    if (out_ch.with_signal !== want.with_signal)
      report($sformatf("with_signal %0d, expected %0d", out_ch.with_signal, want.with_signal));
    if (out_ch.strong_sats !== want.strong_sats)
      report($sformatf("strong_sats %0d, expected %0d", out_ch.strong_sats, want.strong_sats));
    if (out_ch.max_snr !== want.max_snr)
      report($sformatf("max_snr %0d, expected %0d", out_ch.max_snr, want.max_snr));
    if (out_ch.total_in_view !== want.total_in_view)
      report($sformatf("total_in_view %0d, expected %0d", out_ch.total_in_view,
                       want.total_in_view));
    if (out_ch.signal_class !== want.signal_class)
      report($sformatf("signal_class %0d, expected %0d", out_ch.signal_class,
                       want.signal_class));
  endtask

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      chars_taken++;
      gsv_take_char(in_ch.rx_byte);
    end
    if (rst_n && out_ch.valid && out_ch.ready) check_summary();
  end

  // character driver
  always @(negedge clk) begin
    if (rst_n && chars_taken == chars_offered) begin
      if (in_gap > 0) begin
        in_gap--;
        in_ch.valid <= 1'b0;
      end else if (!calm && $urandom_range(0, 15) == 0) begin
        in_gap = $urandom_range(0, 13);
        in_ch.valid <= 1'b0;
      end else if (chars_queued.size() != 0) begin
        in_ch.rx_byte <= chars_queued.pop_front();
        in_ch.valid <= 1'b1;
        chars_offered++;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (out_gap > 0) begin
      out_gap--;
      out_ch.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 11) == 0) begin
      out_gap = $urandom_range(0, 13);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  task automatic push_char(logic [7:0] c);
    chars_queued.push_back(c);
    chars_pushed++;
  endtask

  task automatic push_text(string s);
    int i;
    for (i = 0; i < s.len(); i++) push_char(s[i]);
  endtask

  task automatic push_eol();
    case ($urandom_range(0, 2))
      0: begin
        push_char(CH_CR);
        push_char(CH_LF);
      end
      1: push_char(CH_LF);
      default: push_char(CH_CR);
    endcase
  endtask

  task automatic send_line(string s);
    push_text(s);
    push_eol();
  endtask

  function automatic string blanks(int n);
    string s;
    s = "";
    repeat (n) s = {s, " "};
    return s;
  endfunction

  function automatic string num_field(int lo, int hi);
    logic [7:0] pad;
    case ($urandom_range(0, 3))
      0: pad = CH_TAB;
      1: pad = CH_VT;
      2: pad = CH_FF;
      default: pad = CH_SPACE;
    endcase
    case ($urandom_range(0, 39))
      0: return "";
      1: return $sformatf("-%0d", $urandom_range(1, 99));
      2: return $sformatf("%0d", $urandom_range(10000, 999999));
      3: return $sformatf("%c%0d", pad, $urandom_range(lo, hi));
      4: return $sformatf("+%0d", $urandom_range(lo, hi));
      5: return $sformatf("%0dx", $urandom_range(lo, hi));
      default: return $sformatf("%02d", $urandom_range(lo, hi));
    endcase
  endfunction

  function automatic string gsv_text(int total, int num, string view, int groups);
    string s;
    int g;
    s = $sformatf("$%sGSV,%0d,%0d,%s", talker_ids[$urandom_range(0, 3)], total, num, view);
    for (g = 0; g < groups; g++)
      s = {s, $sformatf(",%s,%02d,%03d,%s", num_field(0, 99), $urandom_range(0, 90),
                        $urandom_range(0, 359),
                        $urandom_range(0, 3) == 0 ? "" : num_field(0, 99))};
    return s;
  endfunction

  function automatic string checksum();
    return $sformatf("*%02X", $urandom_range(0, 255));
  endfunction

  task automatic gsv_cycle();
    int total, num, groups;
    string view, s;
    total = $urandom_range(0, 7) == 0 ? $urandom_range(4, 6) : $urandom_range(1, 3);
    view = num_field(0, 24);
    for (num = 1; num <= total; num++) begin
      groups = num < total ? 4 : $urandom_range(0, 4);
      s = gsv_text(total, num, view, groups);
      if ($urandom_range(0, 9) != 0) s = {s, checksum()};
      if ($urandom_range(0, 24) != 0) send_line(s);
    end
  endtask

  task automatic noise_line();
    if ($urandom_range(0, 1) == 0) push_text("$GPGSV,");
    repeat ($urandom_range(4, 40)) push_char(8'($urandom_range(0, 255)));
    push_eol();
  endtask

  task automatic cut_line();
    string s;
    int cut;
    s = {gsv_text(1, 1, num_field(0, 24), $urandom_range(1, 4)), checksum()};
    cut = $urandom_range(1, s.len() - 1);
    send_line(s.substr(0, cut - 1));
  endtask

  task automatic odd_line();
    string s;
    int cut;
    case ($urandom_range(0, 3))
      0: send_line({gsv_text(1, 1, "04", 3), ",", blanks($urandom_range(40, 120)),
                    "21,30,100,40*00"});
      1: send_line({gsv_text(1, 1, "12", $urandom_range(5, 7)), checksum()});
      2: begin
        s = {gsv_text(1, 1, "08", $urandom_range(1, 4)), checksum()};
        cut = $urandom_range(1, s.len() - 1);
        push_text(s.substr(0, cut - 1));
        push_char(CH_NUL);
        send_line(s.substr(cut, s.len() - 1));
      end
      default: send_line($sformatf("$GPGSV,1,1,0000000000%0d%0d,07,30,100,%0d%0d*00",
                                   $urandom, $urandom, $urandom, $urandom_range(0, 99)));
    endcase
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.idx   <= idx;
    cfg_ch.wdata <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx == REG_STRONG_SNR_MIN) snr_min_r = data[SNR_MIN_W-1:0];
    else if (idx == REG_STRONG_NEEDED) needed_r = data[NEEDED_W-1:0];
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic drain();
    while (chars_taken != chars_pushed || summaries_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic random_phase();
    int k;
    if ($urandom_range(0, 1) == 0) begin
      case ($urandom_range(0, 3))
        0: write_reg(REG_STRONG_SNR_MIN, 7'd0);
        1: write_reg(REG_STRONG_SNR_MIN, 7'd99);
        default: write_reg(REG_STRONG_SNR_MIN, 7'($urandom_range(1, 98)));
      endcase
    end
    if ($urandom_range(0, 1) == 0) begin
      case ($urandom_range(0, 5))
        0: write_reg(REG_STRONG_NEEDED, 7'd1);
        1: write_reg(REG_STRONG_NEEDED, 7'd16);
        2: write_reg(REG_STRONG_NEEDED, 7'd0);
        default: write_reg(REG_STRONG_NEEDED, 7'($urandom_range(2, 15)));
      endcase
    end
    repeat ($urandom_range(1, 4)) begin
      k = $urandom_range(0, 19);
      if (k < 13) gsv_cycle();
      else if (k < 15) noise_line();
      else if (k < 17) cut_line();
      else odd_line();
    end
    drain();
  endtask

  initial begin
    int m, start_chars;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.rx_byte = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.idx = '0;
    cfg_ch.wdata = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed, reset register values
    send_line("$GPGSV,1,1,04,01,40,083,46,02,17,308,41,12,07,344,39,14,22,228,12*75");
    send_line("$GLGSV,2,1,08,65,60,010,30,66,50,020,31,67,40,030,32,68,30,040,33*6A");
    send_line("$GLGSV,2,2,08,69,20,050,00,70,10,060,,71,05,070,-5,00,00,000,45*5B");
    send_line("GPGSV,1,1,01,01,10,100,30*00");
    send_line("$GSV,1,1,0");
    send_line("$GPGGA,1,1,01,05,10,100,30*00");
    push_char(CH_CR);
    push_char(CH_LF);
    push_char(CH_LF);
    push_text("$GPGSV,1,1,03,05,40,100,35");
    push_char(CH_NUL);
    send_line(",06,20,200,40*11");
    push_text("$GPGSV,1,1,02,");
    push_char(8'hC8);
    push_char(8'hFF);
    send_line(",07,30,200,33*00");
    send_line("$GPGSV,1,1,000000000000000012,09,30,100,44*00");
    send_line("$GPGSV,1,1,123456,11,30,100,987654*00");
    send_line("$GPGSV,-1,-1,-7,12,30,100,-20*00");
    send_line("$GPGSV,1,1,-7,13,30,100,25*00");
    send_line($sformatf("$GPGSV, 1,+1,%c04, 14,%c30,100,%c29*00", CH_TAB, CH_VT, CH_FF));
    send_line("$GPGSV,1,1,02,15,30,100,40,16,30,100,41");
    send_line({"$GPGSV,1,1,32", gsv_text(0, 0, "", 0).substr(0, -1),
               ",01,10,100,30,02,10,100,31,03,10,100,32,04,10,100,33",
               ",05,10,100,34,06,10,100,35,07,10,100,36*00"});
    send_line({"$GPGSV,1,1,04,17,30,100,40,18,30,100,41,19,30,100,42,", blanks(90),
               "20,30,100,43*00"});
    for (m = 1; m <= 5; m++)
      send_line($sformatf("$GPGSV,5,%0d,20,%02d,10,100,%0d,%02d,20,110,%0d,%02d,30,120,%0d,%02d,40,130,%0d*00",
                          m, 4 * m - 3, 20 + m, 4 * m - 2, 25 + m, 4 * m - 1, 30 + m,
                          4 * m, 35 + m));
    send_line("$GPGSV,2,1,08,01,40,083,30,02,17,308,31,03,07,344,32,04,22,228,33*70");
    drain();
    // threshold moved between messages of one cycle
    write_reg(REG_STRONG_SNR_MIN, 7'd32);
    send_line("$GPGSV,2,2,08,05,40,083,30,06,17,308,31,07,07,344,32,08,22,228,33*71");
    drain();
    write_reg(REG_STRONG_SNR_MIN, 7'd0);
    write_reg(REG_STRONG_NEEDED, 7'd0);
    send_line("$GPGSV,1,1,02,01,10,100,01,02,10,100,00*00");
    send_line("$GPGSV,1,1,01,03,10,100,*00");
    drain();
    write_reg(REG_STRONG_SNR_MIN, 7'd99);
    write_reg(REG_STRONG_NEEDED, 7'd16);
    send_line("$GPGSV,1,1,02,01,10,100,99,02,10,100,98*00");
    for (m = 1; m <= 4; m++)
      send_line($sformatf("$GPGSV,4,%0d,16,%02d,10,100,99,%02d,10,100,99,%02d,10,100,99,%02d,10,100,99*00",
                          m, 4 * m - 3, 4 * m - 2, 4 * m - 1, 4 * m));
    drain();
    write_reg(REG_STRONG_NEEDED, 7'd1);
    send_line("$GPGSV,1,1,01,05,10,100,98*00");
    drain();

    start_chars = chars_pushed;
    while (chars_pushed - start_chars < 550)
      random_phase();
    calm = 1'b1;
    repeat (2) random_phase();
    repeat (8) @(negedge clk);

    if (errors == 0 && summaries_due.size() == 0) begin
      $display("tb_nmea_gsv_signal_summary passed");
    end else begin
      $display("tb_nmea_gsv_signal_summary failed");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("tb_nmea_gsv_signal_summary failed");
    $finish;
  end

endmodule

[filelist.f]
sv/ngss_pkg.sv
sv/ngss_in_if.sv
sv/ngss_out_if.sv
sv/ngss_cfg_if.sv
sv/nmea_gsv_signal_summary.sv
sv/ngss_checker.sv
sim/tb_nmea_gsv_signal_summary.sv
